FILE: hdl/jhps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and stencil arithmetic for the Jacobi plate solver.
// No dependencies.
package jhps_pkg;

  localparam int MAX_GRID = 64;
  localparam int IDX_W    = $clog2(MAX_GRID);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_GRID * MAX_GRID;
  localparam int CELL_W   = 17;
  localparam int GRID_W   = 7;
  localparam int ITER_W   = 14;
  localparam int CNT_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W    = CELL_W + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

  // Reset values
  localparam logic [GRID_W-1:0] GRID_RST   = 7'd64;
  localparam logic [CELL_W-1:0] THRESH_RST = 17'd6554;
  localparam logic [CELL_W-1:0] HOT_RST    = 17'd49152;
  localparam logic [CELL_W-1:0] COLD_RST   = 17'd29491;
  localparam logic [ITER_W-1:0] ITER_RST   = 14'd10000;

  // Input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef struct packed {
    logic [CELL_W-1:0] val;
    logic              chg;
  } stencil_t;

  // new = (sum + 4*old) >> 3, changing when |4*old - sum| > 4*thr
  function automatic stencil_t stencil(input logic [CELL_W-1:0] old,
                                       input logic [SUM_W-1:0]  part,
                                       input logic [CELL_W-1:0] last,
                                       input logic [CELL_W-1:0] thr);
    logic [SUM_W-1:0] sum_all;
    logic [SUM_W-1:0] four;
    logic [SUM_W:0]   tot;
    logic [SUM_W-1:0] dev;
    stencil_t         r;
    sum_all = part + {2'b00, last};
    four    = {old, 2'b00};
    tot     = {1'b0, sum_all} + {1'b0, four};
    dev     = (four >= sum_all) ? (four - sum_all) : (sum_all - four);
    r.val   = tot[SUM_W:3];
    r.chg   = dev > {thr, 2'b00};
    return r;
  endfunction

endpackage

FILE: hdl/jacobi_heat_plate_solver.sv
`timescale 1ns / 1ps
// Jacobi heat plate solver, top level. Uses jhps_pkg and jhps_ram.
// Load word: written into both plate RAMs, no result.
// Run word: each sweep makes five reads per cell on the single read port of
// the source RAM, then one write; after the last sweep the plate is tallied
// and one result word follows. Sync reset restores config defaults
// and clears control state; plate RAMs are undefined until loaded.
module jacobi_heat_plate_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [jhps_pkg::IDX_W-1:0]    row,
  input  logic [jhps_pkg::IDX_W-1:0]    col,
  input  logic [jhps_pkg::CELL_W-1:0]   cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jhps_pkg::ITER_W-1:0]   iteration_count,
  output logic [jhps_pkg::CNT_W-1:0]    hot_cells,
  output logic [jhps_pkg::CNT_W-1:0]    cold_cells,
  output logic [jhps_pkg::CNT_W-1:0]    transition_cells,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jhps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jhps_pkg::CELL_W-1:0]   cfg_data
);
  import jhps_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // config registers
  logic [GRID_W-1:0] grid_size;
  logic [CELL_W-1:0] change_threshold;
  logic [CELL_W-1:0] hot_floor;
  logic [CELL_W-1:0] cold_ceiling;
  logic [ITER_W-1:0] iteration_limit;

  logic [2:0]        state;
  logic              front_select;
  logic [ITER_W-1:0] sweep_counter;
  logic              any_change;
  logic [IDX_W-1:0]  si, sj;       // current cell
  logic [IDX_W-1:0]  edge_in;      // n-2, last interior index
  logic [IDX_W-1:0]  edge_out;     // n-1, last index
  logic [2:0]        phase;        // stencil read phase 0..5
  logic [CELL_W-1:0] old_val;
  logic [SUM_W-1:0]  sum_acc;
  logic              tally_valid;
  logic [CNT_W-1:0]  hot_cnt, cold_cnt, mid_cnt;

  logic              in_acc, load_acc, run_acc;
  logic [GRID_W-1:0] n_clamp;
  logic [CELL_W-1:0] rd_a, rd_b, rd_src;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [CELL_W-1:0] wdata;
  logic              sweep_wr, we_a, we_b;
  logic              cell_last;
  logic [ITER_W-1:0] sweep_counter_next;
  stencil_t          st;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && (kind == KIND_LOAD);
  assign run_acc   = in_acc && (kind == KIND_RUN);

  always_comb begin
    if (grid_size < GRID_W'(3)) begin
      n_clamp = GRID_W'(3);
    end else if (grid_size > GRID_W'(MAX_GRID)) begin
      n_clamp = GRID_W'(MAX_GRID);
    end else begin
      n_clamp = grid_size;
    end
  end

  // source buffer is front when front_select is 0
  assign rd_src = front_select ? rd_b : rd_a;
  assign st     = stencil(old_val, sum_acc, rd_src, change_threshold);

  assign sweep_wr  = (state == ST_SWEEP) && (phase == 3'd5);
  assign cell_last = (si == edge_in) && (sj == edge_in);
  assign sweep_counter_next = sweep_counter + ITER_W'(1);

  // stencil read order: center, up, down, left, right
  always_comb begin
    raddr = {si, sj};
    if (state == ST_SWEEP) begin
      unique case (phase)
        3'd1:    raddr = {si - IDX_W'(1), sj};
        3'd2:    raddr = {si + IDX_W'(1), sj};
        3'd3:    raddr = {si, sj - IDX_W'(1)};
        3'd4:    raddr = {si, sj + IDX_W'(1)};
        default: raddr = {si, sj};
      endcase
    end
  end

  assign waddr = load_acc ? {row, col} : {si, sj};
  assign wdata = load_acc ? cell_value : st.val;
  assign we_a  = load_acc || (sweep_wr && front_select);
  assign we_b  = load_acc || (sweep_wr && !front_select);

  jhps_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_front (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_a)
  );

  jhps_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_back (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_b)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size        <= GRID_RST;
      change_threshold <= THRESH_RST;
      hot_floor        <= HOT_RST;
      cold_ceiling     <= COLD_RST;
      iteration_limit  <= ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_SIZE:  grid_size        <= cfg_data[GRID_W-1:0];
        REG_THRESHOLD:  change_threshold <= cfg_data;
        REG_HOT_LIMIT:  hot_floor        <= cfg_data;
        REG_COLD_LIMIT: cold_ceiling     <= cfg_data;
        REG_ITER_LIMIT: iteration_limit  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      front_select  <= 1'b0;
      sweep_counter <= '0;
      any_change    <= 1'b0;
      phase         <= '0;
      tally_valid   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      tally_valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (run_acc) begin
            edge_in       <= IDX_W'(n_clamp - GRID_W'(2));
            edge_out      <= IDX_W'(n_clamp - GRID_W'(1));
            si            <= IDX_W'(1);
            sj            <= IDX_W'(1);
            phase         <= '0;
            sweep_counter <= '0;
            any_change    <= 1'b0;
            state         <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          phase <= phase + 3'd1;
          if (phase == 3'd1) begin
            old_val <= rd_src;
          end else if (phase == 3'd2) begin
            sum_acc <= {2'b00, rd_src};
          end else if (phase == 3'd3 || phase == 3'd4) begin
            sum_acc <= sum_acc + {2'b00, rd_src};
          end
          if (phase == 3'd5) begin
            phase <= '0;
            if (sj == edge_in) begin
              sj <= IDX_W'(1);
              si <= si + IDX_W'(1);
            end else begin
              sj <= sj + IDX_W'(1);
            end
            if (cell_last) begin
              front_select  <= !front_select;
              sweep_counter <= sweep_counter_next;
              si            <= IDX_W'(1);
              sj            <= IDX_W'(1);
              if ((any_change || st.chg) && (sweep_counter_next < iteration_limit)) begin
                any_change <= 1'b0;
              end else begin
                si       <= '0;
                sj       <= '0;
                hot_cnt  <= '0;
                cold_cnt <= '0;
                mid_cnt  <= '0;
                state    <= ST_COUNT;
              end
            end else if (st.chg) begin
              any_change <= 1'b1;
            end
          end
        end
        ST_COUNT: begin
          tally_valid <= 1'b1;
          if (sj == edge_out) begin
            sj <= '0;
            si <= si + IDX_W'(1);
            if (si == edge_out) begin
              state <= ST_DRAIN;
            end
          end else begin
            sj <= sj + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            iteration_count  <= sweep_counter;
            hot_cells        <= hot_cnt;
            cold_cells       <= cold_cnt;
            transition_cells <= mid_cnt;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // tally each cell in the cycle after its read
      if (tally_valid) begin
        if (rd_src >= hot_floor) begin
          hot_cnt <= hot_cnt + CNT_W'(1);
        end else if (rd_src <= cold_ceiling) begin
          cold_cnt <= cold_cnt + CNT_W'(1);
        end else begin
          mid_cnt <= mid_cnt + CNT_W'(1);
        end
      end
    end
  end

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (phase <= 3'd5))
    else $error("stencil phase out of range");

  a_tally_src: assert property (@(posedge clk) disable iff (rst)
    tally_valid |-> ($past(state) == ST_COUNT))
    else $error("tally without count read");

  a_sweep_interior: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (si != '0 && sj != '0 && si <= edge_in && sj <= edge_in))
    else $error("sweep touched a border cell");
`endif

endmodule

FILE: hdl/jhps_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module jhps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Jacobi heat plate solver.
// Depends on jhps_pkg and jacobi_heat_plate_solver; a local predictor
// mirrors the plate buffers and the sweep/tally rules.
module testbench;
  import jhps_pkg::*;

  // Result word as the block reports it
  typedef struct packed {
    logic [ITER_W-1:0] sweeps;
    logic [CNT_W-1:0]  hot;
    logic [CNT_W-1:0]  cold;
    logic [CNT_W-1:0]  trans;
  } tally_t;

  // One row of the directed table
  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [CELL_W-1:0] v;
    bit                typed;
    tally_t            want;
  } stim_t;

  logic clk, rst;
  logic in_valid, in_ready, kind;
  logic [IDX_W-1:0] row, col;
  logic [CELL_W-1:0] cell_value;
  logic out_valid, out_ready;
  logic [ITER_W-1:0] iteration_count;
  logic [CNT_W-1:0] hot_cells, cold_cells, transition_cells;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CELL_W-1:0] cfg_data;

  jacobi_heat_plate_solver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .row(row), .col(col), .cell_value(cell_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .iteration_count(iteration_count), .hot_cells(hot_cells),
    .cold_cells(cold_cells), .transition_cells(transition_cells),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------
  // Predictor state: two plate buffers, front pointer, config copy
  // ---------------------------------------------------------------
  logic [CELL_W-1:0] plate [2][DEPTH];
  bit                loaded [DEPTH];
  bit                front;
  int unsigned       p_grid, p_thr, p_hot, p_cold, p_iter;

  tally_t      tally_q [$];   // expected tallies, oldest first
  int          errors;
  int          runs_sent;
  bit          in_fire, cfg_fire;

  // Grid size as the block clamps it
  function automatic int eff_grid();
    if (p_grid < 3) return 3;
    if (p_grid > MAX_GRID) return MAX_GRID;
    return p_grid;
  endfunction

  // Jacobi sweeps until settled or at the limit, then tally the plate
  function automatic tally_t solve_plate();
    int n, i, j, k, chg, sweeps, hot, cold;
    int unsigned old, sum, four, dev;
    tally_t t;
    n = eff_grid();
    sweeps = 0;
    do begin
      chg = 0;
      for (i = 1; i < n - 1; i++)
        for (j = 1; j < n - 1; j++) begin
          k = i * MAX_GRID + j;
          old = plate[front][k];
          sum = plate[front][k + MAX_GRID] + plate[front][k - MAX_GRID]
              + plate[front][k + 1] + plate[front][k - 1];
          four = 4 * old;
          dev = (four >= sum) ? four - sum : sum - four;
          plate[!front][k] = CELL_W'((sum + four) >> 3);
          if (dev > 4 * p_thr) chg++;
        end
      front = !front;
      sweeps = (sweeps + 1) & 'h3FFF;
    end while (chg > 0 && sweeps < p_iter);
    hot = 0;
    cold = 0;
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) begin
        if (plate[front][i * MAX_GRID + j] >= p_hot) hot++;
        else if (plate[front][i * MAX_GRID + j] <= p_cold) cold++;
      end
    t.sweeps = ITER_W'(sweeps);
    t.hot    = CNT_W'(hot);
    t.cold   = CNT_W'(cold);
    t.trans  = CNT_W'(n * n - hot - cold);
    return t;
  endfunction

  // ---------------------------------------------------------------
  // Clock, reset, handshake sampling
  // ---------------------------------------------------------------
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // fire flags latched at the edge, read by the drivers at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // Short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word; on acceptance update the predictor
  task automatic send_word(input logic k, input int r, input int c,
                           input logic [CELL_W-1:0] v,
                           input bit typed, input tally_t want);
    int gap;
    tally_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    row = IDX_W'(r);
    col = IDX_W'(c);
    cell_value = v;
    in_valid = 1;
    do @(negedge clk); while (!in_fire);
    if (k == KIND_LOAD) begin
      plate[0][r * MAX_GRID + c] = v;
      plate[1][r * MAX_GRID + c] = v;
      loaded[r * MAX_GRID + c] = 1;
    end else begin
      got = solve_plate();
      tally_q.push_back(typed ? want : got);
      runs_sent++;
    end
  endtask

  task automatic load_cell(input int r, input int c, input logic [CELL_W-1:0] v);
    send_word(KIND_LOAD, r, c, v, 0, '0);
  endtask

  // Load whatever cells of the active plate were never written
  task automatic fill_missing();
    int i, j, n;
    n = eff_grid();
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++)
        if (!loaded[i * MAX_GRID + j])
          load_cell(i, j, CELL_W'($urandom_range(0, 65536)));
  endtask

  // Register write, only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned d);
    in_valid = 0;
    while (tally_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_index = idx;
    cfg_data = CELL_W'(d);
    cfg_valid = 1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid = 0;
    case (idx)
      REG_GRID_SIZE:  p_grid = d & 'h7F;
      REG_THRESHOLD:  p_thr  = d & 'h1FFFF;
      REG_HOT_LIMIT:  p_hot  = d & 'h1FFFF;
      REG_COLD_LIMIT: p_cold = d & 'h1FFFF;
      REG_ITER_LIMIT: p_iter = d & 'h3FFF;
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned g, input int unsigned th,
                           input int unsigned h, input int unsigned cl,
                           input int unsigned it);
    write_reg(REG_GRID_SIZE, g);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_HOT_LIMIT, h);
    write_reg(REG_COLD_LIMIT, cl);
    write_reg(REG_ITER_LIMIT, it);
  endtask

  // ---------------------------------------------------------------
  // Result side: random stalls plus one long hold-off
  // ---------------------------------------------------------------
  initial begin
    bit held;
    int r;
    held = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!held && runs_sent >= 8) begin
        // long back-pressure so the block stalls its input side
        held = 1;
        out_ready = 0;
        repeat (4000) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) out_ready = 1;
      else if (r < 95) out_ready = 0;
      else begin
        out_ready = 0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  // Compare each accepted word against the oldest expected tally
  always @(posedge clk) begin
    tally_t want;
    if (!rst && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: iter=%0d hot=%0d cold=%0d trans=%0d",
                   iteration_count, hot_cells, cold_cells, transition_cells);
      end else begin
        want = tally_q.pop_front();
        if (want.sweeps !== iteration_count || want.hot !== hot_cells ||
            want.cold !== cold_cells || want.trans !== transition_cells) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want iter=%0d hot=%0d cold=%0d trans=%0d, got %0d %0d %0d %0d",
                     want.sweeps, want.hot, want.cold, want.trans, iteration_count,
                     hot_cells, cold_cells, transition_cells);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  stim_t plan [$];

  function automatic void add_row(input logic k, input int r, input int c,
                                  input int unsigned v, input bit typed,
                                  input tally_t want);
    stim_t s;
    s.kind = k;
    s.r = IDX_W'(r);
    s.c = IDX_W'(c);
    s.v = CELL_W'(v);
    s.typed = typed;
    s.want = want;
    plan.push_back(s);
  endfunction

  initial begin
    int i, ph, it, n, r;
    int unsigned g, th, h, cl, il, v;
    rst = 1;
    in_valid = 0;
    kind = KIND_LOAD;
    row = '0;
    col = '0;
    cell_value = '0;
    cfg_valid = 0;
    cfg_index = REG_GRID_SIZE;
    cfg_data = '0;
    errors = 0;
    runs_sent = 0;
    front = 0;
    p_grid = GRID_RST;
    p_thr = THRESH_RST;
    p_hot = HOT_RST;
    p_cold = COLD_RST;
    p_iter = ITER_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part on a 3x3 plate with default limits
    write_reg(REG_GRID_SIZE, 3);
    for (i = 0; i < 9; i++) add_row(KIND_LOAD, i / 3, i % 3, 0, 0, '0);
    add_row(KIND_RUN, 0, 0, 0, 1, '{14'd1, 13'd0, 13'd9, 13'd0});  // cold, settled
    for (i = 0; i < 9; i++) add_row(KIND_LOAD, i / 3, i % 3, 65536, 0, '0);
    add_row(KIND_RUN, 0, 0, 0, 1, '{14'd1, 13'd9, 13'd0, 13'd0});  // all at 1.0
    add_row(KIND_LOAD, 1, 1, 0, 0, '0);          // cold center, hot border
    add_row(KIND_RUN, 0, 0, 0, 0, '0);
    add_row(KIND_LOAD, 1, 1, 131071, 0, '0);     // largest raw cell value
    add_row(KIND_LOAD, 63, 63, 131071, 0, '0);   // stored, outside the plate
    add_row(KIND_LOAD, 0, 63, 0, 0, '0);
    add_row(KIND_RUN, 0, 0, 0, 0, '0);
    foreach (plan[k])
      send_word(plan[k].kind, plan[k].r, plan[k].c, plan[k].v,
                plan[k].typed, plan[k].want);

    // Random phases, each with its own register settings
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin g = 3; th = 0; h = 65536; cl = 0; il = 16383; end
        1: begin g = 0; th = 65536; h = 0; cl = 65536; il = 0; end
        2: begin g = 2; th = 131071; h = 131071; cl = 131071; il = 1; end
        default: begin
          g  = $urandom_range(3, 8);
          th = $urandom_range(0, 20000);
          h  = $urandom_range(0, 65536);
          cl = $urandom_range(0, 65536);
          il = $urandom_range(1, 40);
        end
      endcase
      write_all(g, th, h, cl, il);
      n = eff_grid();
      fill_missing();
      for (it = 0; it < 100; it++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_word(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                    CELL_W'($urandom), 0, '0);
        end else begin
          v = (r < 20) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
          if (r < 14) load_cell($urandom_range(0, 63), $urandom_range(0, 63), CELL_W'(v));
          else load_cell($urandom_range(0, n - 1), $urandom_range(0, n - 1), CELL_W'(v));
        end
      end
      send_word(KIND_RUN, 0, 0, 0, 0, '0);
    end
    in_valid = 0;

    while (tally_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #800000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
